// ----- sv/mce_pkg.sv -----
// Shared types and constants for the Monte Carlo option pricer.
// Used by every module of the block; has no dependencies.
package mce_pkg;

  localparam int FRAC_BITS = 16;
  localparam int EXP_FRAC  = 40;
  localparam int TAYLOR_N  = 24;
  localparam int DVD_W     = 60;
  localparam int DSR_W     = 16;
  localparam int X_W       = 26;

  // ln2 in Q.40, rounded to nearest
  localparam logic [47:0] LN2_Q40 = 48'h00B1_7217_F7D2;
  localparam logic signed [X_W-1:0] X_OVER  = X_W'(23 <<< FRAC_BITS);
  localparam logic signed [X_W-1:0] X_UNDER = -X_W'((FRAC_BITS + 2) <<< FRAC_BITS);

  localparam logic [2:0] CFG_LOG_DRIFT  = 3'd0;
  localparam logic [2:0] CFG_VOL_ROOT_T = 3'd1;
  localparam logic [2:0] CFG_STRIKE     = 3'd2;
  localparam logic [2:0] CFG_DISCOUNT   = 3'd3;
  localparam logic [2:0] CFG_IS_PUT     = 3'd4;
  localparam logic [2:0] CFG_SIMS       = 3'd5;
  localparam logic [2:0] CFG_REPS       = 3'd6;

  typedef enum logic [1:0] {
    CLS_NORMAL = 2'd0,
    CLS_OVER   = 2'd1,
    CLS_UNDER  = 2'd2
  } cls_t;

  typedef struct packed {
    logic signed [21:0] log_drift;
    logic [19:0]        vol_root_t;
    logic [31:0]        strike;
    logic [16:0]        discount;
    logic               is_put;
    logic [15:0]        sims_per_rep;
    logic [7:0]         reps;
  } cfg_t;

  typedef struct packed {
    cls_t                   cls;
    logic signed [X_W-1:0]  x;
  } qent_t;

  typedef struct packed {
    logic               start;
    logic [DVD_W-1:0]   dividend;
    logic [DSR_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DVD_W-1:0]   quotient;
  } div_rsp_t;

endpackage

// ----- sv/mce_front.sv -----
// Front end: takes a normal sample, forms the log price and classifies it.
// Depends on mce_pkg.
module mce_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mce_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [15:0]            in_normal_sample,
  output logic                          push_valid,
  input  logic                          push_ready,
  output mce_pkg::qent_t                push_data
);

  logic                          v_r;
  mce_pkg::qent_t                ent_r;
  logic signed [36:0]            prod;
  logic signed [36:0]            prod_rnd;
  logic signed [mce_pkg::X_W-1:0] x_w;
  mce_pkg::qent_t                ent_nxt;

  assign in_ready   = !v_r || push_ready;
  assign push_valid = v_r;
  assign push_data  = ent_r;

  always_comb begin
    prod     = $signed({1'b0, cfg.vol_root_t}) * in_normal_sample;
    prod_rnd = prod + 37'sd2048;
    // arithmetic shift gives the floor
    x_w      = mce_pkg::X_W'(cfg.log_drift) + mce_pkg::X_W'(prod_rnd >>> 12);
    ent_nxt.x = x_w;
    if (x_w >= mce_pkg::X_OVER) begin
      ent_nxt.cls = mce_pkg::CLS_OVER;
    end else if (x_w <= mce_pkg::X_UNDER) begin
      ent_nxt.cls = mce_pkg::CLS_UNDER;
    end else begin
      ent_nxt.cls = mce_pkg::CLS_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      v_r <= 1'b1;
    end else if (push_ready) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ent_r <= ent_nxt;
    end
  end

endmodule

// ----- sv/mce_queue.sv -----
// Two-entry queue between the front end and the pricing engine.
// Depends on mce_pkg.
module mce_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  mce_pkg::qent_t  push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output mce_pkg::qent_t  pop_data
);

  mce_pkg::qent_t ent_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = ent_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- sv/mce_div.sv -----
// Shared restoring divider, four quotient bits per cycle.
// Depends on mce_pkg.
module mce_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mce_pkg::div_req_t req,
  output mce_pkg::div_rsp_t rsp
);

  localparam int STEPS = 4;
  localparam int ITERS = mce_pkg::DVD_W / STEPS;
  localparam int CNT_W = $clog2(ITERS);

  logic                        busy_r;
  logic                        done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [mce_pkg::DVD_W-1:0]   dvd_r;
  logic [mce_pkg::DSR_W-1:0]   rem_r;
  logic [mce_pkg::DSR_W-1:0]   dsr_r;
  logic [mce_pkg::DVD_W-1:0]   dvd_nxt;
  logic [mce_pkg::DSR_W-1:0]   rem_nxt;
  logic [mce_pkg::DSR_W:0]     wide;

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

  always_comb begin
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    wide    = '0;
    for (int k = 0; k < STEPS; k++) begin
      wide    = {rem_nxt, dvd_nxt[mce_pkg::DVD_W-1]};
      dvd_nxt = {dvd_nxt[mce_pkg::DVD_W-2:0], 1'b0};
      if (wide >= {1'b0, dsr_r}) begin
        wide       = wide - {1'b0, dsr_r};
        dvd_nxt[0] = 1'b1;
      end
      rem_nxt = wide[mce_pkg::DSR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ITERS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

// ----- sv/mce_back.sv -----
// Pricing engine: exp by range reduction and Taylor series, payoff,
// replication and final statistics, result register. Depends on mce_pkg.
module mce_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mce_pkg::cfg_t       cfg,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  mce_pkg::qent_t      pop_data,
  output mce_pkg::div_req_t   div_req,
  input  mce_pkg::div_rsp_t   div_rsp,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_kind,
  output logic [31:0]         out_value,
  output logic signed [32:0]  out_lower_bound,
  output logic [32:0]         out_upper_bound,
  output logic                out_saturated,
  output logic                out_last
);

  typedef enum logic [28:0] {
    ST_IDLE    = 29'd1 << 0,
    ST_RED     = 29'd1 << 1,
    ST_TM_HI   = 29'd1 << 2,
    ST_TM_LO   = 29'd1 << 3,
    ST_TDIV_GO = 29'd1 << 4,
    ST_TDIV    = 29'd1 << 5,
    ST_SHIFT   = 29'd1 << 6,
    ST_PAY     = 29'd1 << 7,
    ST_MDIV_GO = 29'd1 << 8,
    ST_MDIV    = 29'd1 << 9,
    ST_VM_HI   = 29'd1 << 10,
    ST_VM_LO   = 29'd1 << 11,
    ST_VSUM    = 29'd1 << 12,
    ST_VRND    = 29'd1 << 13,
    ST_SQ_HI   = 29'd1 << 14,
    ST_SQ_LO   = 29'd1 << 15,
    ST_SQSUM   = 29'd1 << 16,
    ST_REP     = 29'd1 << 17,
    ST_FDIV_M  = 29'd1 << 18,
    ST_FWAIT_M = 29'd1 << 19,
    ST_FDIV_A  = 29'd1 << 20,
    ST_FWAIT_A = 29'd1 << 21,
    ST_MM_HI   = 29'd1 << 22,
    ST_MM_LO   = 29'd1 << 23,
    ST_MMSUM   = 29'd1 << 24,
    ST_BVAL    = 29'd1 << 25,
    ST_VAR     = 29'd1 << 26,
    ST_SQRT    = 29'd1 << 27,
    ST_FOUT    = 29'd1 << 28
  } state_t;

  localparam logic [63:0] HALF_LSB = 64'd1 << (mce_pkg::FRAC_BITS - 1);

  state_t               st_r;
  logic signed [47:0]   r_r;
  logic signed [6:0]    q_r;
  logic [40:0]          term_r;
  logic [41:0]          sum_r;
  logic [4:0]           i_r;
  logic [31:0]          price_r;
  logic                 sat_r;
  logic [47:0]          psum_r;
  logic [15:0]          cnt_r;
  logic [7:0]           rep_r;
  logic [39:0]          msum_r;
  logic [55:0]          msq_r;
  logic [47:0]          mean_r;
  logic [31:0]          val_r;
  logic [65:0]          mult_r;
  logic [65:0]          acc_r;
  logic [63:0]          tmp_r;
  logic [39:0]          m_r;
  logic [56:0]          a_r;
  logic [63:0]          v_r;
  logic [63:0]          res_r;
  logic [63:0]          bit_r;
  logic [32:0]          sd_r;

  logic                 out_valid_r;
  logic                 out_kind_r;
  logic [31:0]          out_value_r;
  logic signed [32:0]   out_lower_r;
  logic [32:0]          out_upper_r;
  logic                 out_sat_r;
  logic                 out_last_r;

  logic [41:0]          mul_a;
  logic [23:0]          mul_b;
  logic [65:0]          mul_p;
  logic [65:0]          tq;
  logic [15:0]          sims_eff;
  logic [7:0]           reps_eff;
  logic [15:0]          cnt_inc;
  logic [7:0]           rep_inc;
  logic                 out_free;
  logic                 out_load;
  logic signed [7:0]    sh_s;
  logic [63:0]          sh_v;
  logic [31:0]          payoff;
  logic [63:0]          rnd;
  logic [56:0]          var_w;
  logic [63:0]          res_bit;
  logic [40:0]          low_w;
  logic [40:0]          up_w;

  assign pop_ready       = (st_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_value       = out_value_r;
  assign out_lower_bound = out_lower_r;
  assign out_upper_bound = out_upper_r;
  assign out_saturated   = out_sat_r;
  assign out_last        = out_last_r;

  assign sims_eff = (cfg.sims_per_rep == 16'd0) ? 16'd1 : cfg.sims_per_rep;
  assign reps_eff = (cfg.reps == 8'd0) ? 8'd1 : cfg.reps;
  assign cnt_inc  = cnt_r + 16'd1;
  assign rep_inc  = rep_r + 8'd1;
  assign out_free = !out_valid_r || out_ready;
  // a result beat is loaded in either output state once the register frees up
  assign out_load = ((st_r == ST_REP) || (st_r == ST_FOUT)) && out_free;
  assign mul_p    = {24'b0, mul_a} * {42'b0, mul_b};
  assign tq       = acc_r + {20'b0, mult_r[65:20]};
  assign res_bit  = res_r + bit_r;
  assign low_w    = {1'b0, m_r} - {8'b0, sd_r};
  assign up_w     = {1'b0, m_r} + {8'b0, sd_r};

  // multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_r)
      ST_TM_HI: begin mul_a = {1'b0, term_r}; mul_b = {4'b0, r_r[39:20]}; end
      ST_TM_LO: begin mul_a = {1'b0, term_r}; mul_b = {4'b0, r_r[19:0]}; end
      ST_VM_HI: begin mul_a = {25'b0, cfg.discount}; mul_b = mean_r[47:24]; end
      ST_VM_LO: begin mul_a = {25'b0, cfg.discount}; mul_b = mean_r[23:0]; end
      ST_SQ_HI: begin mul_a = {10'b0, val_r}; mul_b = {8'b0, val_r[31:16]}; end
      ST_SQ_LO: begin mul_a = {10'b0, val_r}; mul_b = {8'b0, val_r[15:0]}; end
      ST_MM_HI: begin mul_a = {2'b0, m_r}; mul_b = {8'b0, m_r[39:24]}; end
      ST_MM_LO: begin mul_a = {2'b0, m_r}; mul_b = m_r[23:0]; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // divider requests
  always_comb begin
    div_req = '0;
    case (st_r)
      ST_TDIV_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {14'b0, tq[65:20]};
        div_req.divisor  = {11'b0, i_r};
      end
      ST_MDIV_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {12'b0, psum_r} + {45'b0, cnt_r[15:1]};
        div_req.divisor  = cnt_r;
      end
      ST_FDIV_M: begin
        div_req.start    = 1'b1;
        div_req.dividend = {20'b0, msum_r} + {53'b0, rep_r[7:1]};
        div_req.divisor  = {8'b0, rep_r};
      end
      ST_FDIV_A: begin
        div_req.start    = 1'b1;
        div_req.dividend = {4'b0, msq_r} + {53'b0, rep_r[7:1]};
        div_req.divisor  = {8'b0, rep_r};
      end
      default: div_req = '0;
    endcase
  end

  // final scale of exp(r) by 2^q, rounded
  always_comb begin
    sh_s = 8'sd24 - {q_r[6], q_r};
    if (sh_s <= 8'sd0) begin
      sh_v = {22'b0, sum_r} << 6'(-sh_s);
    end else begin
      sh_v = ({22'b0, sum_r} + (64'd1 << (6'(sh_s) - 6'd1))) >> 6'(sh_s);
    end
  end

  always_comb begin
    if (cfg.is_put) begin
      payoff = (cfg.strike > price_r) ? cfg.strike - price_r : 32'd0;
    end else begin
      payoff = (price_r > cfg.strike) ? price_r - cfg.strike : 32'd0;
    end
    rnd   = tmp_r + HALF_LSB;
    var_w = (a_r > {9'b0, tmp_r[47:0]}) ? a_r - {9'b0, tmp_r[47:0]} : 57'd0;
  end

  always_ff @(posedge clk) begin
    mult_r <= mul_p;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      sat_r       <= 1'b0;
      psum_r      <= '0;
      cnt_r       <= '0;
      rep_r       <= '0;
      msum_r      <= '0;
      msq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          if (pop_valid) begin
            case (pop_data.cls)
              mce_pkg::CLS_OVER: begin
                price_r <= '1;
                sat_r   <= 1'b1;
                st_r    <= ST_PAY;
              end
              mce_pkg::CLS_UNDER: begin
                price_r <= '0;
                st_r    <= ST_PAY;
              end
              default: begin
                r_r  <= {pop_data.x[23:0], 24'b0};
                q_r  <= '0;
                st_r <= ST_RED;
              end
            endcase
          end
        end
        ST_RED: begin
          if (r_r < 0) begin
            r_r <= r_r + $signed(mce_pkg::LN2_Q40);
            q_r <= q_r - 7'sd1;
          end else if (r_r >= $signed(mce_pkg::LN2_Q40)) begin
            r_r <= r_r - $signed(mce_pkg::LN2_Q40);
            q_r <= q_r + 7'sd1;
          end else begin
            term_r <= 41'd1 << mce_pkg::EXP_FRAC;
            sum_r  <= 42'd1 << mce_pkg::EXP_FRAC;
            i_r    <= 5'd1;
            st_r   <= ST_TM_HI;
          end
        end
        ST_TM_HI: st_r <= ST_TM_LO;
        ST_TM_LO: begin
          acc_r <= mult_r;
          st_r  <= ST_TDIV_GO;
        end
        ST_TDIV_GO: st_r <= ST_TDIV;
        ST_TDIV: begin
          if (div_rsp.done) begin
            term_r <= div_rsp.quotient[40:0];
            sum_r  <= sum_r + {1'b0, div_rsp.quotient[40:0]};
            if (i_r == 5'(mce_pkg::TAYLOR_N)) begin
              st_r <= ST_SHIFT;
            end else begin
              i_r  <= i_r + 5'd1;
              st_r <= ST_TM_HI;
            end
          end
        end
        ST_SHIFT: begin
          if (|sh_v[63:32]) begin
            price_r <= '1;
            sat_r   <= 1'b1;
          end else begin
            price_r <= sh_v[31:0];
          end
          st_r <= ST_PAY;
        end
        ST_PAY: begin
          psum_r <= psum_r + {16'b0, payoff};
          cnt_r  <= cnt_inc;
          st_r   <= (cnt_inc >= sims_eff) ? ST_MDIV_GO : ST_IDLE;
        end
        ST_MDIV_GO: st_r <= ST_MDIV;
        ST_MDIV: begin
          if (div_rsp.done) begin
            mean_r <= div_rsp.quotient[47:0];
            st_r   <= ST_VM_HI;
          end
        end
        ST_VM_HI: st_r <= ST_VM_LO;
        ST_VM_LO: begin
          acc_r <= mult_r;
          st_r  <= ST_VSUM;
        end
        ST_VSUM: begin
          tmp_r <= {acc_r[39:0], 24'b0} + mult_r[63:0];
          st_r  <= ST_VRND;
        end
        ST_VRND: begin
          // discounted mean clamps to the top code
          val_r <= (|rnd[63:48]) ? '1 : rnd[47:16];
          st_r  <= ST_SQ_HI;
        end
        ST_SQ_HI: st_r <= ST_SQ_LO;
        ST_SQ_LO: begin
          acc_r <= mult_r;
          st_r  <= ST_SQSUM;
        end
        ST_SQSUM: begin
          tmp_r <= {acc_r[47:0], 16'b0} + mult_r[63:0];
          st_r  <= ST_REP;
        end
        ST_REP: begin
          if (out_free) begin
            msq_r        <= msq_r + {8'b0, rnd[63:16]};
            msum_r       <= msum_r + {8'b0, val_r};
            rep_r        <= rep_inc;
            psum_r       <= '0;
            cnt_r        <= '0;
            out_kind_r   <= 1'b0;
            out_value_r  <= val_r;
            out_lower_r  <= '0;
            out_upper_r  <= '0;
            out_sat_r    <= sat_r;
            if (rep_inc >= reps_eff) begin
              out_last_r <= 1'b0;
              st_r       <= ST_FDIV_M;
            end else begin
              out_last_r <= 1'b1;
              sat_r      <= 1'b0;
              st_r       <= ST_IDLE;
            end
          end
        end
        ST_FDIV_M: st_r <= ST_FWAIT_M;
        ST_FWAIT_M: begin
          if (div_rsp.done) begin
            m_r  <= div_rsp.quotient[39:0];
            st_r <= ST_FDIV_A;
          end
        end
        ST_FDIV_A: st_r <= ST_FWAIT_A;
        ST_FWAIT_A: begin
          if (div_rsp.done) begin
            a_r  <= div_rsp.quotient[56:0];
            st_r <= ST_MM_HI;
          end
        end
        ST_MM_HI: st_r <= ST_MM_LO;
        ST_MM_LO: begin
          acc_r <= mult_r;
          st_r  <= ST_MMSUM;
        end
        ST_MMSUM: begin
          tmp_r <= {acc_r[39:0], 24'b0} + mult_r[63:0];
          st_r  <= ST_BVAL;
        end
        ST_BVAL: begin
          tmp_r <= {16'b0, rnd[63:16]};
          st_r  <= ST_VAR;
        end
        ST_VAR: begin
          // too large to scale: root of the top code
          v_r   <= (|var_w[56:48]) ? '1 : {var_w[47:0], 16'b0};
          res_r <= '0;
          bit_r <= 64'd1 << 62;
          st_r  <= ST_SQRT;
        end
        ST_SQRT: begin
          if (bit_r != 64'd0) begin
            if (v_r >= res_bit) begin
              v_r   <= v_r - res_bit;
              res_r <= (res_r >> 1) + bit_r;
            end else begin
              res_r <= res_r >> 1;
            end
            bit_r <= bit_r >> 2;
          end else begin
            sd_r <= res_r[32:0] + {32'b0, (v_r > res_r)};
            st_r <= ST_FOUT;
          end
        end
        ST_FOUT: begin
          if (out_free) begin
            out_kind_r  <= 1'b1;
            out_value_r <= m_r[31:0];
            out_lower_r <= low_w[32:0];
            out_upper_r <= up_w[32:0];
            out_sat_r   <= sat_r;
            out_last_r  <= 1'b1;
            sat_r       <= 1'b0;
            rep_r       <= '0;
            msum_r      <= '0;
            msq_r       <= '0;
            st_r        <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/monte_carlo_european_option.sv -----
// Top level of the Monte Carlo European option pricer: configuration
// registers, front end, queue, pricing engine and divider. Depends on mce_pkg.
//
//  channel  direction  signals
//  in       input      in_valid, in_ready, in_normal_sample
//  out      output     out_valid, out_ready, out_kind, out_value, out_lower_bound,
//                      out_upper_bound, out_saturated, out_last
//  cfg      input      cfg_we, cfg_index, cfg_data
//
// A saturating or underflowing sample goes straight to the payoff; any other runs
// range reduction by ln2, then 24 Taylor terms of two multiplier passes and one
// divider pass each. A replication end adds a mean division and multiplies for
// the discounted mean and its square; the final statistics two divisions, a
// multiply and a square root. Reset is synchronous. The two-entry queue takes
// samples while the engine works; a held result stalls it, and once full, input.
module monte_carlo_european_option (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_normal_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic [31:0]        out_value,
  output logic signed [32:0] out_lower_bound,
  output logic [32:0]        out_upper_bound,
  output logic               out_saturated,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  mce_pkg::cfg_t      cfg_r;
  logic               push_valid;
  logic               push_ready;
  mce_pkg::qent_t     push_data;
  logic               pop_valid;
  logic               pop_ready;
  mce_pkg::qent_t     pop_data;
  mce_pkg::div_req_t  div_req;
  mce_pkg::div_rsp_t  div_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.log_drift    <= '0;
      cfg_r.vol_root_t   <= '0;
      cfg_r.strike       <= '0;
      cfg_r.discount     <= 17'd65536;
      cfg_r.is_put       <= 1'b0;
      cfg_r.sims_per_rep <= 16'd1;
      cfg_r.reps         <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        mce_pkg::CFG_LOG_DRIFT:  cfg_r.log_drift    <= cfg_data[21:0];
        mce_pkg::CFG_VOL_ROOT_T: cfg_r.vol_root_t   <= cfg_data[19:0];
        mce_pkg::CFG_STRIKE:     cfg_r.strike       <= cfg_data;
        mce_pkg::CFG_DISCOUNT:   cfg_r.discount     <= cfg_data[16:0];
        mce_pkg::CFG_IS_PUT:     cfg_r.is_put       <= cfg_data[0];
        mce_pkg::CFG_SIMS:       cfg_r.sims_per_rep <= cfg_data[15:0];
        mce_pkg::CFG_REPS:       cfg_r.reps         <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  mce_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_normal_sample (in_normal_sample),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_data        (push_data)
  );

  mce_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  mce_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  mce_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_data        (pop_data),
    .div_req         (div_req),
    .div_rsp         (div_rsp),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_value       (out_value),
    .out_lower_bound (out_lower_bound),
    .out_upper_bound (out_upper_bound),
    .out_saturated   (out_saturated),
    .out_last        (out_last)
  );

endmodule

// ----- test/monte_carlo_european_option_checker.sv -----
// Checker for the Monte Carlo option pricer: mirrors its configuration and
// accumulators, predicts each result beat and compares. Depends on mce_pkg.
`timescale 1ns / 1ps

module monte_carlo_european_option_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] in_normal_sample,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_kind,
  input  logic [31:0]        out_value,
  input  logic signed [32:0] out_lower_bound,
  input  logic [32:0]        out_upper_bound,
  input  logic               out_saturated,
  input  logic               out_last,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);

  localparam int FB = mce_pkg::FRAC_BITS;

  typedef struct {
    bit        kind;
    bit [31:0] value;
    bit [32:0] lower;
    bit [32:0] upper;
    bit        sat;
    bit        last;
  } price_result_t;

  price_result_t     expected_q[$];
  mce_pkg::cfg_t     cfg;
  longint unsigned   payoff_sum, sample_count, rep_count;
  longint unsigned   mean_sum, mean_sq_sum;
  bit                sat_seen;
  longint signed     ln2_q40;

  initial begin
    longint unsigned acc;
    acc = 0;
    for (int k = 1; k < 62; k++) acc += (64'd1 << (62 - k)) / k;
    ln2_q40 = longint'((acc + (64'd1 << 21)) >> 22);
  end

  assign pending = expected_q.size();

  function automatic void queue_result(price_result_t r);
    expected_q = {expected_q, r};
  endfunction

  function automatic longint unsigned mul40(longint unsigned a, longint unsigned b);
    longint unsigned hi, lo;
    hi = b >> 20;
    lo = b & 64'hF_FFFF;
    return ((a * hi) + ((a * lo) >> 20)) >> 20;
  endfunction

  // terminal price in Q16.16, flags saturation
  function automatic longint unsigned terminal_price(longint signed x, output bit sat);
    longint signed   x40, q, r, s;
    longint unsigned sum, term, v;
    sat = 0;
    if (x >= (64'sd23 <<< FB)) begin
      sat = 1;
      return 64'hFFFF_FFFF;
    end
    if (x <= -(longint'(FB + 2) <<< FB)) return 0;
    x40 = x * (64'sd1 <<< (40 - FB));
    q = x40 / ln2_q40;
    r = x40 - q * ln2_q40;
    if (r < 0) begin
      r += ln2_q40;
      q--;
    end
    sum = 64'd1 << 40;
    term = sum;
    for (longint unsigned i = 1; i <= 24; i++) begin
      term = mul40(term, longint'(r)) / i;
      sum += term;
    end
    s = 40 - FB - q;
    if (s <= 0) v = sum << (-s);
    else if (s >= 63) v = 0;
    else v = (sum + (64'd1 << (s - 1))) >> s;
    if (v > 64'hFFFF_FFFF) begin
      sat = 1;
      v = 64'hFFFF_FFFF;
    end
    return v;
  endfunction

  function automatic longint unsigned sqrt_nearest(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    if (v > res) res++;
    return res;
  endfunction

  task automatic price_sample(logic signed [15:0] z_in);
    longint signed   z, ld, prod, x;
    longint unsigned price, payoff, n, mean, val, sims, nreps, m, a, b, var_v, sd;
    bit              sat;
    price_result_t   rep, fin;
    z = z_in;
    ld = cfg.log_drift;
    prod = longint'(cfg.vol_root_t) * z;
    x = ld + ((prod + 2048) >>> 12);
    price = terminal_price(x, sat);
    if (sat) sat_seen = 1;
    if (cfg.is_put) payoff = (cfg.strike > price) ? cfg.strike - price : 0;
    else payoff = (price > cfg.strike) ? price - cfg.strike : 0;
    payoff_sum = (payoff_sum + payoff) & 64'hFFFF_FFFF_FFFF;
    sample_count++;
    sims = (cfg.sims_per_rep != 0) ? cfg.sims_per_rep : 1;
    if (sample_count < sims) return;

    n = sample_count;
    mean = (payoff_sum + n / 2) / n;
    val = (mean * cfg.discount + (64'd1 << (FB - 1))) >> FB;
    if (val > 64'hFFFF_FFFF) val = 64'hFFFF_FFFF;
    mean_sum = (mean_sum + val) & 64'hFF_FFFF_FFFF;
    mean_sq_sum = (mean_sq_sum + ((val * val + (64'd1 << (FB - 1))) >> FB))
                  & 64'hFF_FFFF_FFFF_FFFF;
    rep_count++;
    rep = '{kind: 0, value: val[31:0], lower: 0, upper: 0, sat: sat_seen, last: 1};
    payoff_sum = 0;
    sample_count = 0;
    nreps = (cfg.reps != 0) ? cfg.reps : 1;
    if (rep_count < nreps) begin
      sat_seen = 0;
      queue_result(rep);
      return;
    end
    // run complete: final statistics follow the replication beat
    rep.last = 0;
    queue_result(rep);
    n = rep_count;
    m = (mean_sum + n / 2) / n;
    a = (mean_sq_sum + n / 2) / n;
    b = (m * m + (64'd1 << (FB - 1))) >> FB;
    var_v = (a > b) ? a - b : 0;
    if (var_v > (64'hFFFF_FFFF_FFFF_FFFF >> FB)) begin
      sd = sqrt_nearest(64'hFFFF_FFFF_FFFF_FFFF);
    end else begin
      sd = sqrt_nearest(var_v << FB);
    end
    fin.kind = 1;
    fin.value = m[31:0];
    fin.lower = 33'(m - sd);
    fin.upper = 33'(m + sd);
    fin.sat = sat_seen;
    fin.last = 1;
    queue_result(fin);
    sat_seen = 0;
    rep_count = 0;
    mean_sum = 0;
    mean_sq_sum = 0;
  endtask

  always @(posedge clk) begin
    price_result_t exp_r;
    if (!rst_n) begin
      cfg <= '{log_drift: '0, vol_root_t: '0, strike: '0, discount: 17'd65536,
               is_put: 1'b0, sims_per_rep: 16'd1, reps: 8'd1};
      payoff_sum = 0;
      sample_count = 0;
      rep_count = 0;
      mean_sum = 0;
      mean_sq_sum = 0;
      sat_seen = 0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mce_pkg::CFG_LOG_DRIFT:  cfg.log_drift <= cfg_data[21:0];
          mce_pkg::CFG_VOL_ROOT_T: cfg.vol_root_t <= cfg_data[19:0];
          mce_pkg::CFG_STRIKE:     cfg.strike <= cfg_data;
          mce_pkg::CFG_DISCOUNT:   cfg.discount <= cfg_data[16:0];
          mce_pkg::CFG_IS_PUT:     cfg.is_put <= cfg_data[0];
          mce_pkg::CFG_SIMS:       cfg.sims_per_rep <= cfg_data[15:0];
          mce_pkg::CFG_REPS:       cfg.reps <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) price_sample(in_normal_sample);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected: kind %0d value %0h", out_kind, out_value);
          fail_count++;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_kind !== exp_r.kind) begin
            $error("kind: expected %0d actual %0d", exp_r.kind, out_kind);
            fail_count++;
          end
          if (out_value !== exp_r.value) begin
            $error("value: expected %0h actual %0h", exp_r.value, out_value);
            fail_count++;
          end
          if (out_lower_bound !== exp_r.lower) begin
            $error("lower_bound: expected %0h actual %0h", exp_r.lower, out_lower_bound);
            fail_count++;
          end
          if (out_upper_bound !== exp_r.upper) begin
            $error("upper_bound: expected %0h actual %0h", exp_r.upper, out_upper_bound);
            fail_count++;
          end
          if (out_saturated !== exp_r.sat) begin
            $error("saturated: expected %0d actual %0d", exp_r.sat, out_saturated);
            fail_count++;
          end
          if (out_last !== exp_r.last) begin
            $error("last: expected %0d actual %0d", exp_r.last, out_last);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ----- test/monte_carlo_european_option_tb.sv -----
// Testbench top for the Monte Carlo option pricer: drives samples, settings
// and back-pressure, and gives the verdict. Depends on mce_pkg and the checker.
`timescale 1ns / 1ps

module monte_carlo_european_option_tb;

  localparam int WATCHDOG = 20000;
  // up to four samples can still be in the engine with no result due
  localparam int SETTLE   = 3000;
  localparam int HOLD_LEN = 1500;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_normal_sample = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_kind;
  logic [31:0]        out_value;
  logic signed [32:0] out_lower_bound;
  logic [32:0]        out_upper_bound;
  logic               out_saturated;
  logic               out_last;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  int                 fail_count, pending;
  int                 quiet_cycles = 0;
  bit                 no_idle = 0;
  bit                 hold_req = 0;

  monte_carlo_european_option u_dut (.*);

  monte_carlo_european_option_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("monte_carlo_european_option test failed");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_sample(logic signed [15:0] z);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_normal_sample <= z;
    do @(posedge clk); while (!in_ready);
  endtask

  // ends a phase: all beats in, then let any sample with no result finish
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_config(logic [31:0] ld, logic [31:0] vol, logic [31:0] k,
                              logic [31:0] disc, logic [31:0] put, logic [31:0] sims,
                              logic [31:0] reps);
    logic [31:0] vals [7];
    vals[mce_pkg::CFG_LOG_DRIFT]  = ld;
    vals[mce_pkg::CFG_VOL_ROOT_T] = vol;
    vals[mce_pkg::CFG_STRIKE]     = k;
    vals[mce_pkg::CFG_DISCOUNT]   = disc;
    vals[mce_pkg::CFG_IS_PUT]     = put;
    vals[mce_pkg::CFG_SIMS]       = sims;
    vals[mce_pkg::CFG_REPS]       = reps;
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] draw_sample();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 12000)) - 6000);
  endfunction

  initial begin
    logic [31:0] ld, vol, k;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // plain call, three reps of one sample, sample extremes
    write_config(0, 65536, 65536, 65536, 0, 1, 3);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd0);
    send_sample(16'sd4096);
    drain();
    // price overflow, zero counts act as one, discounted mean clamps
    write_config(23 << 16, 0, 0, 131071, 0, 0, 0);
    send_sample(16'sd0);
    send_sample(16'sd1);
    drain();
    // price underflow on a put with top strike
    write_config(-(18 << 16), 0, 32'hFFFF_FFFF, 65536, 1, 2, 2);
    repeat (4) send_sample(draw_sample());
    drain();
    // largest vol, sample extremes drive both tails
    write_config(-(2 << 16), 1048575, 65536, 65536, 1, 4, 1);
    send_sample(-16'sd32768);
    send_sample(16'sd32767);
    send_sample(16'sd0);
    send_sample(16'sd1);
    drain();
    // replication length lowered part way through
    write_config(0, 16384, 0, 65536, 0, 5, 1);
    send_sample(16'sd2048);
    send_sample(-16'sd2048);
    drain();
    write_config(0, 16384, 0, 65536, 0, 1, 1);
    send_sample(16'sd100);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      no_idle = (phase == 2);
      if (phase == 7) begin
        ld = 32'($signed($urandom_range(0, 2097151)) - 1048576);
        write_config(ld, 1048575, 32'hFFFF_FFFF, 131071, 1, 1, 255);
      end else begin
        ld = ($urandom_range(0, 4) == 0) ? $urandom
             : 32'($signed($urandom_range(0, 10 << 16)) - (4 << 16));
        vol = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 1 << 18);
        k = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 1 << 20);
        write_config(ld, vol, k, $urandom_range(0, 131071), $urandom_range(0, 1),
                     (phase == 4) ? 1 : $urandom_range(1, 4),
                     (phase == 4) ? 1 : $urandom_range(1, 5));
      end
      if (phase == 4) hold_req = 1;
      repeat (135) send_sample(draw_sample());
      drain();
    end
    no_idle = 0;

    if (fail_count == 0 && pending == 0) begin
      $display("monte_carlo_european_option test passed");
    end else begin
      $display("monte_carlo_european_option test failed");
    end
    $finish;
  end

endmodule
